// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

  // Element and quotient width, work width of the divider datapath.
  localparam int QW = 32;
  localparam int WW = 128;
  localparam int CW = 64;  // cofactor magnitude
  localparam int DW = 96;  // determinant magnitude

  typedef logic signed [QW-1:0] elem_t;

  typedef struct packed {
    logic [CW-1:0] cmag;
    logic [DW-1:0] dmag;
    logic          neg;
    logic          zero;
  } div_in_t;

  typedef struct packed {
    logic [QW-1:0] b;
    logic          zero;
  } div_out_t;

endpackage

// ===== rtl/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse by the adjugate. Each transfer on the input side
// carries one matrix of nine signed fixed-point elements with FRAC_BITS
// fraction bits, and the matching output transfer carries its inverse,
// truncated toward zero and saturated to 32 bits, plus a singular flag that
// is set (with all elements zero) when the determinant is exactly zero. The
// block accepts one matrix every cycle while in_stall is low. The front stages
// form the products, cofactors and the exact determinant, and the nine
// dividers follow with a scaling stage, 32 stages of one quotient bit each
// and a saturating output register. The whole pipeline holds while a
// finished result waits on a stalled output, and moves again as soon as it
// is taken.
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mi3_pkg::elem_t      a00,
  input  mi3_pkg::elem_t      a10,
  input  mi3_pkg::elem_t      a20,
  input  mi3_pkg::elem_t      a01,
  input  mi3_pkg::elem_t      a11,
  input  mi3_pkg::elem_t      a21,
  input  mi3_pkg::elem_t      a02,
  input  mi3_pkg::elem_t      a12,
  input  mi3_pkg::elem_t      a22,
  output logic                out_valid,
  input  logic                out_stall,
  output mi3_pkg::elem_t      b00,
  output mi3_pkg::elem_t      b10,
  output mi3_pkg::elem_t      b20,
  output mi3_pkg::elem_t      b01,
  output mi3_pkg::elem_t      b11,
  output mi3_pkg::elem_t      b21,
  output mi3_pkg::elem_t      b02,
  output mi3_pkg::elem_t      b12,
  output mi3_pkg::elem_t      b22,
  output logic                singular
);
  import mi3_pkg::*;

  localparam int FRONT = 7;
  localparam int DIV_LAT = QW + 2;
  localparam int NST = FRONT + DIV_LAT;

  // The pipeline advances whenever the output register is free or is
  // being taken in this cycle.
  logic adv;
  logic [NST-1:0] vld;

  assign adv = !vld[NST-1] || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // Stage 1: the eighteen 2x2 products. With a00..a22 indexed by row, then
  // column, the pairs follow the adjugate in output order.
  logic signed [63:0] prod [0:17];
  elem_t x1 [0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      prod[0]  <= 64'(a11) * 64'(a22);  prod[1]  <= 64'(a12) * 64'(a21);
      prod[2]  <= 64'(a12) * 64'(a20);  prod[3]  <= 64'(a10) * 64'(a22);
      prod[4]  <= 64'(a10) * 64'(a21);  prod[5]  <= 64'(a11) * 64'(a20);
      prod[6]  <= 64'(a02) * 64'(a21);  prod[7]  <= 64'(a01) * 64'(a22);
      prod[8]  <= 64'(a00) * 64'(a22);  prod[9]  <= 64'(a02) * 64'(a20);
      prod[10] <= 64'(a01) * 64'(a20);  prod[11] <= 64'(a00) * 64'(a21);
      prod[12] <= 64'(a01) * 64'(a12);  prod[13] <= 64'(a02) * 64'(a11);
      prod[14] <= 64'(a02) * 64'(a10);  prod[15] <= 64'(a00) * 64'(a12);
      prod[16] <= 64'(a00) * 64'(a11);  prod[17] <= 64'(a01) * 64'(a10);
      x1[0] <= a00;
      x1[1] <= a01;
      x1[2] <= a02;
    end
  end

  // Stage 2: exact cofactors.
  logic signed [64:0] minor [0:8];
  elem_t x2 [0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        minor[j] <= 65'(prod[2*j]) - 65'(prod[2*j+1]);
      end
      x2 <= x1;
    end
  end

  // Stage 3: sign and magnitude of the cofactors and of the first row.
  logic [CW-1:0] cm3 [0:8];
  logic          cn3 [0:8];
  logic [QW-1:0] xm3 [0:2];
  logic          xn3 [0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        cm3[j] <= minor[j][64] ? CW'(-minor[j]) : CW'(minor[j]);
        cn3[j] <= minor[j][64];
      end
      for (int t = 0; t < 3; t++) begin
        xm3[t] <= x2[t][QW-1] ? (QW'(0) - x2[t]) : x2[t];
        xn3[t] <= x2[t][QW-1];
      end
    end
  end

  // Stage 4: 32x64 determinant terms as two 32x32 partial products.
  logic [63:0]   pl4 [0:2];
  logic [63:0]   ph4 [0:2];
  logic          tn4 [0:2];
  logic [CW-1:0] cm4 [0:8];
  logic          cn4 [0:8];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 3; t++) begin
        pl4[t] <= 64'(xm3[t]) * 64'(cm3[t][31:0]);
        ph4[t] <= 64'(xm3[t]) * 64'(cm3[t][63:32]);
        tn4[t] <= xn3[t] ^ cn3[t];
      end
      cm4 <= cm3;
      cn4 <= cn3;
    end
  end

  // Stage 5: combine the partial products and apply the term sign.
  logic signed [DW:0] term5 [0:2];
  logic [CW-1:0]      cm5 [0:8];
  logic               cn5 [0:8];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 3; t++) begin
        term5[t] <= tn4[t] ? -((DW+1)'(pl4[t]) + ((DW+1)'(ph4[t]) << 32))
                           :  ((DW+1)'(pl4[t]) + ((DW+1)'(ph4[t]) << 32));
      end
      cm5 <= cm4;
      cn5 <= cn4;
    end
  end

  // Stage 6: exact determinant.
  logic signed [DW+1:0] det6;
  logic [CW-1:0]        cm6 [0:8];
  logic                 cn6 [0:8];
  always_ff @(posedge clk) begin
    if (adv) begin
      det6 <= (DW+2)'(term5[0]) + (DW+2)'(term5[1]) + (DW+2)'(term5[2]);
      cm6 <= cm5;
      cn6 <= cn5;
    end
  end

  // Stage 7: determinant magnitude and the singular test.
  logic [DW-1:0] dm7;
  logic          dn7;
  logic          dz7;
  logic [CW-1:0] cm7 [0:8];
  logic          cn7 [0:8];
  always_ff @(posedge clk) begin
    if (adv) begin
      dm7 <= det6[DW+1] ? DW'(-det6) : DW'(det6);
      dn7 <= det6[DW+1];
      dz7 <= (det6 == '0);
      cm7 <= cm6;
      cn7 <= cn6;
    end
  end

  div_in_t  din [0:8];
  div_out_t res [0:8];

  for (genvar j = 0; j < 9; j++) begin : g_div
    assign din[j] = '{cmag: cm7[j], dmag: dm7, neg: cn7[j] ^ dn7, zero: dz7};
    mi3_div #(
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .din (din[j]),
      .dout(res[j])
    );
  end

  assign b00 = res[0].b;
  assign b10 = res[1].b;
  assign b20 = res[2].b;
  assign b01 = res[3].b;
  assign b11 = res[4].b;
  assign b21 = res[5].b;
  assign b02 = res[6].b;
  assign b12 = res[7].b;
  assign b22 = res[8].b;
  assign singular = res[0].zero;

endmodule

// ===== rtl/mi3_div.sv =====
module mi3_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              en,
  input  mi3_pkg::div_in_t  din,
  output mi3_pkg::div_out_t dout
);
  import mi3_pkg::*;

  logic [WW-1:0] r_s [0:QW];
  logic [DW-1:0] d_s [0:QW];
  logic [QW-1:0] q_s [0:QW];
  logic          neg_s [0:QW];
  logic          zero_s [0:QW];
  logic          ovf_s [0:QW];

  logic [WW-1:0] n;
  assign n = WW'(din.cmag) << (2 * FRAC_BITS);

  // First stage: scale the numerator and catch quotients of 2^32 or more.
  always_ff @(posedge clk) begin
    if (en) begin
      r_s[0]    <= n;
      d_s[0]    <= din.dmag;
      q_s[0]    <= '0;
      neg_s[0]  <= din.neg;
      zero_s[0] <= din.zero;
      ovf_s[0]  <= (n >= (WW'(din.dmag) << QW));
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int SH = QW - k;
    logic [WW-1:0] dsh;
    assign dsh = WW'(d_s[k-1]) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        if (r_s[k-1] >= dsh) begin
          r_s[k] <= r_s[k-1] - dsh;
          q_s[k] <= q_s[k-1] | (QW'(1) << SH);
        end else begin
          r_s[k] <= r_s[k-1];
          q_s[k] <= q_s[k-1];
        end
        d_s[k]    <= d_s[k-1];
        neg_s[k]  <= neg_s[k-1];
        zero_s[k] <= zero_s[k-1];
        ovf_s[k]  <= ovf_s[k-1];
      end
    end
  end

  logic [QW-1:0] q;
  logic [QW-1:0] b_next;
  assign q = q_s[QW];

  always_comb begin
    if (zero_s[QW]) begin
      b_next = '0;
    end else if (!neg_s[QW]) begin
      b_next = (ovf_s[QW] || q[QW-1]) ? {1'b0, {(QW-1){1'b1}}} : q;
    end else if (ovf_s[QW] || (q > {1'b1, {(QW-1){1'b0}}})) begin
      b_next = {1'b1, {(QW-1){1'b0}}};
    end else begin
      b_next = QW'(0) - q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.b    <= b_next;
      dout.zero <= zero_s[QW];
    end
  end

endmodule
